// File: sv/serial_frame_checker_defines.svh
// Assertion macros shared by the frame checker RTL.
// Each macro expects clk and arst_n to be visible at the point of use.
`ifndef SERIAL_FRAME_CHECKER_DEFINES_SVH
`define SERIAL_FRAME_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/sfc_pkg.sv
`default_nettype none

package sfc_pkg;

	// Frame positions and bytes are both eight bits wide.
	typedef logic [7:0] byte_t;
	typedef logic [7:0] pos_t;

	// Default buffer size in bytes.
	localparam int unsigned BUF_LEN_DEF = 64;

	// Frame marker bytes.
	localparam byte_t SYNC0    = 8'hF7;
	localparam byte_t SYNC1    = 8'hF8;
	localparam byte_t TYPE0    = 8'h01;
	localparam byte_t TYPE1    = 8'h02;
	localparam byte_t END_MARK = 8'hFD;

	// Fixed positions inside a frame.
	localparam pos_t POS_SYNC0 = 8'd0;
	localparam pos_t POS_SYNC1 = 8'd1;
	localparam pos_t POS_LEN   = 8'd2;
	localparam pos_t POS_TYPE1 = 8'd4;
	localparam pos_t POS_BODY  = 8'd5;

	// Offset from the length byte to the end marker position.
	localparam logic [8:0] END_OFFSET = 9'd3;

	// One result beat.
	typedef struct packed {
		pos_t byte_index;
		pos_t next_index;
		logic frame_ok;
		logic frame_dropped;
	} sfc_result_t;

endpackage

`default_nettype wire

// File: sv/sfc_rx_if.sv
`default_nettype none

// Received byte channel.
interface sfc_rx_if;
	logic          valid;
	logic          ready;
	sfc_pkg::byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: sv/sfc_res_if.sv
`default_nettype none

// Per-byte result channel.
interface sfc_res_if;
	logic         valid;
	logic         ready;
	sfc_pkg::pos_t byte_index;
	sfc_pkg::pos_t next_index;
	logic         frame_ok;
	logic         frame_dropped;

	modport source (
		output valid, output byte_index, output next_index,
		output frame_ok, output frame_dropped, input ready
	);
	modport sink (
		input valid, input byte_index, input next_index,
		input frame_ok, input frame_dropped, output ready
	);
endinterface

`default_nettype wire

// File: sv/sfc_core.sv
`default_nettype none
`include "serial_frame_checker_defines.svh"

// Frame parser state and the per-byte decision logic.
module sfc_core #(
	parameter int unsigned BUF_LEN = sfc_pkg::BUF_LEN_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire sfc_pkg::byte_t      rx_byte,
	output sfc_pkg::sfc_result_t     result
);

	localparam logic [8:0] BUF_LEN_W = 9'(BUF_LEN);

	sfc_pkg::pos_t  pos_q, pos_d;
	sfc_pkg::byte_t len_q, len_d;
	sfc_pkg::byte_t sum_q, sum_d;
	sfc_pkg::byte_t prev_q;
	logic           type_ok_q, type_ok_d;

	logic [8:0]     nxt;
	logic [8:0]     end_pos;
	sfc_pkg::byte_t body_sum;
	logic           ok;
	logic           drop;

	// Decide the next position and the frame flags for the current byte.
	always_comb begin
		nxt       = {1'b0, pos_q} + 9'd1;
		ok        = 1'b0;
		drop      = 1'b0;
		len_d     = len_q;
		sum_d     = sum_q;
		type_ok_d = type_ok_q;
		end_pos   = {1'b0, len_q} + sfc_pkg::END_OFFSET;
		// Sum of the body is the total so far minus the checksum byte.
		body_sum  = sum_q - prev_q;

		// Running checksum starts at the length byte.
		if (pos_q == sfc_pkg::POS_LEN) begin
			len_d = rx_byte;
			sum_d = rx_byte;
		end else if (pos_q > sfc_pkg::POS_LEN) begin
			sum_d = sum_q + rx_byte;
		end

		// Header, type and end checks; the type check wins over the end check.
		if (pos_q == sfc_pkg::POS_SYNC0) begin
			if (rx_byte != sfc_pkg::SYNC0) begin
				nxt = 9'd0;
			end
		end else if (pos_q == sfc_pkg::POS_SYNC1) begin
			if (rx_byte != sfc_pkg::SYNC1) begin
				nxt  = 9'd0;
				drop = 1'b1;
			end
		end else if (pos_q == sfc_pkg::POS_TYPE1) begin
			if (prev_q == sfc_pkg::TYPE0 && rx_byte == sfc_pkg::TYPE1) begin
				type_ok_d = 1'b1;
			end else begin
				type_ok_d = 1'b0;
				nxt       = 9'd0;
				drop      = 1'b1;
			end
		end else if (pos_q > sfc_pkg::POS_LEN && {1'b0, pos_q} == end_pos) begin
			if (rx_byte == sfc_pkg::END_MARK && body_sum == prev_q) begin
				ok = 1'b1;
			end else begin
				drop = 1'b1;
			end
			nxt = 9'd0;
		end

		// Wrap at the end of the buffer.
		if (nxt >= BUF_LEN_W) begin
			nxt = 9'd0;
		end
		if (nxt == 9'd0) begin
			type_ok_d = 1'b0;
		end
		pos_d = nxt[7:0];
	end

	// Result fields for this byte.
	always_comb begin
		result.byte_index    = pos_q;
		result.next_index    = pos_d;
		result.frame_ok      = ok;
		result.frame_dropped = drop;
	end

	// Parser state advances once per byte handed to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			len_q     <= '0;
			sum_q     <= '0;
			prev_q    <= '0;
			type_ok_q <= 1'b0;
		end else if (adv) begin
			pos_q     <= pos_d;
			len_q     <= len_d;
			sum_q     <= sum_d;
			prev_q    <= rx_byte;
			type_ok_q <= type_ok_d;
		end
	end

	// The type flag is set exactly while parsing the frame body.
	`SFC_ASSERT_IMPL(a_type_flag, 1'b1, type_ok_q == (pos_q >= sfc_pkg::POS_BODY), "type flag out of step with position")
	// The position never reaches the buffer size.
	`SFC_ASSERT_IMPL(a_pos_range, 1'b1, {1'b0, pos_q} < BUF_LEN_W, "position past buffer end")
	// A byte never both accepts and drops a frame.
	`SFC_ASSERT_IMPL(a_flags_excl, adv, !(ok && drop), "frame accepted and dropped together")
	// Any accepted or dropped frame restarts at position zero.
	`SFC_ASSERT_NEXT(a_restart, adv && (ok || drop), pos_q == sfc_pkg::POS_SYNC0, "no restart after frame end")

endmodule

`default_nettype wire

// File: sv/serial_frame_checker.sv
// Serial frame checker.
// rx carries one received byte per beat; res carries one result beat per byte:
// the position at which the byte was stored, the position expected next, and
// flags for a frame accepted (header, checksum, end marker and, in a non-empty
// frame, type all good) and a frame dropped (mismatch, parsing restarts at position zero).
// Both channels use a valid/ready handshake; a beat moves when both are high.
// A byte accepted into the input register goes through the decision logic, and
// its result is offered once it is loaded into the result register.
// Throughput: one byte per cycle while res does not stall, set by the single
// input register followed by one level of decision logic into the result register.
// When res stalls, the held result stays in the result register and one more
// byte can wait in the input register; rx.ready drops only when both are full.
// Reset (arst_n low, asynchronous) empties both registers and returns the
// parser to position zero with a cleared checksum.
// BUF_LEN sets the buffer size; a position that would reach it wraps to zero.
`default_nettype none

module serial_frame_checker #(
	parameter int unsigned BUF_LEN = sfc_pkg::BUF_LEN_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	sfc_rx_if.sink     rx,
	sfc_res_if.source  res
);

	logic                 valid_s1;
	sfc_pkg::byte_t       rx_byte_s1;
	logic                 res_valid_s2;
	sfc_pkg::sfc_result_t res_s2;
	sfc_pkg::sfc_result_t result;
	logic                 out_free;
	logic                 adv;

	// Stage handshake: the result register frees when empty or when taken.
	assign out_free = !res_valid_s2 || res.ready;
	assign adv      = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || out_free;

	// Input register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	// Input register data.
	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			rx_byte_s1 <= rx.rx_byte;
		end
	end

	sfc_core #(
		.BUF_LEN (BUF_LEN)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.rx_byte (rx_byte_s1),
		.result  (result)
	);

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (out_free) begin
			res_valid_s2 <= valid_s1;
		end
	end

	// Result register data.
	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= result;
		end
	end

	// Drive the result channel.
	assign res.valid         = res_valid_s2;
	assign res.byte_index    = res_s2.byte_index;
	assign res.next_index    = res_s2.next_index;
	assign res.frame_ok      = res_s2.frame_ok;
	assign res.frame_dropped = res_s2.frame_dropped;

endmodule

`default_nettype wire

// File: tb/testbench.sv
`default_nettype none

module testbench;

	localparam int unsigned BUF_LEN = sfc_pkg::BUF_LEN_DEF;
	localparam int unsigned RANDOM_BYTES = 1250;
	localparam int unsigned QUIET_LIMIT = 2000;

	// Ways to spoil a frame on purpose.
	localparam int unsigned FLAW_NONE = 0;
	localparam int unsigned FLAW_SYNC = 1;
	localparam int unsigned FLAW_TYPE = 2;
	localparam int unsigned FLAW_SUM  = 3;
	localparam int unsigned FLAW_END  = 4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sfc_rx_if  rx_ch ();
	sfc_res_if res_ch ();

	serial_frame_checker #(.BUF_LEN(BUF_LEN)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch.sink),
		.res    (res_ch.source)
	);

	// Clock with a period of 10.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sfc_pkg::byte_t       pending_bytes[$];
	sfc_pkg::sfc_result_t expected_results[$];
	int unsigned   total_items = 1;
	int unsigned   bytes_sent = 0;
	int unsigned   phase = 0;
	logic          draining = 1'b0;
	logic          drive_next;
	int unsigned   mismatch_count = 0;
	int unsigned   frames_ok = 0;
	int unsigned   frames_dropped = 0;
	int unsigned   wraps_seen = 0;
	int unsigned   quiet_cycles = 0;
	sfc_pkg::sfc_result_t want;

	// Parser state as the block should hold it.
	sfc_pkg::byte_t parse_pos = '0;
	sfc_pkg::byte_t frame_len = '0;
	logic           type_seen = 1'b0;
	sfc_pkg::byte_t frame_sum = '0;
	sfc_pkg::byte_t last_byte = '0;

	// Advance the parser by one received byte and return the result beat it causes.
	function automatic sfc_pkg::sfc_result_t parse_byte(input sfc_pkg::byte_t b);
		sfc_pkg::sfc_result_t r;
		int unsigned p;
		int unsigned nxt;
		sfc_pkg::byte_t sum_before;
		sfc_pkg::byte_t body;
		p = parse_pos;
		nxt = p + 1;
		sum_before = frame_sum;
		r.frame_ok = 1'b0;
		r.frame_dropped = 1'b0;

		if (p == sfc_pkg::POS_LEN) begin
			frame_len = b;
			frame_sum = b;
		end else if (p > sfc_pkg::POS_LEN) begin
			frame_sum = frame_sum + b;
		end

		if (p == sfc_pkg::POS_SYNC0) begin
			if (b != sfc_pkg::SYNC0)
				nxt = 0;
		end else if (p == sfc_pkg::POS_SYNC1) begin
			if (b != sfc_pkg::SYNC1) begin
				nxt = 0;
				r.frame_dropped = 1'b1;
			end
		end else if (p == sfc_pkg::POS_TYPE1) begin
			if (last_byte == sfc_pkg::TYPE0 && b == sfc_pkg::TYPE1) begin
				type_seen = 1'b1;
			end else begin
				type_seen = 1'b0;
				nxt = 0;
				r.frame_dropped = 1'b1;
			end
		end else if (p >= sfc_pkg::END_OFFSET && p == frame_len + sfc_pkg::END_OFFSET) begin
			// The byte before the end marker is the checksum; the sum of the
			// body is the running total less that byte.
			body = sum_before - last_byte;
			if (b == sfc_pkg::END_MARK && body == last_byte)
				r.frame_ok = 1'b1;
			else
				r.frame_dropped = 1'b1;
			nxt = 0;
		end

		if (nxt >= BUF_LEN)
			nxt = 0;
		if (nxt == 0)
			type_seen = 1'b0;

		last_byte = b;
		parse_pos = sfc_pkg::byte_t'(nxt);
		r.byte_index = sfc_pkg::byte_t'(p);
		r.next_index = sfc_pkg::byte_t'(nxt);
		return r;
	endfunction

	// Build one frame of the given length, optionally spoiled, and queue its bytes.
	// Lengths whose end marker can never be reached run on to the buffer wrap.
	task automatic queue_frame(input int unsigned len, input int unsigned flaw);
		sfc_pkg::byte_t f[$];
		sfc_pkg::byte_t chk;
		logic  has_end;
		f = {sfc_pkg::SYNC0, sfc_pkg::SYNC1, sfc_pkg::byte_t'(len)};
		has_end = (len == 0) || (len >= 3 && len + 3 < BUF_LEN);
		if (len == 0) begin
			f.push_back(sfc_pkg::END_MARK);
		end else begin
			f.push_back(sfc_pkg::TYPE0);
			f.push_back(sfc_pkg::TYPE1);
			if (len >= 3 && len + 3 < BUF_LEN) begin
				for (int i = 5; i <= len + 1; i++)
					f.push_back(sfc_pkg::byte_t'($urandom));
				chk = '0;
				for (int i = 2; i <= len + 1; i++)
					chk += f[i];
				f.push_back(chk);
				f.push_back(sfc_pkg::END_MARK);
			end else if (len == 2) begin
				// The checksum slot falls on the type byte, so this one drops.
				f.push_back(sfc_pkg::END_MARK);
			end else begin
				while (f.size() < BUF_LEN)
					f.push_back(sfc_pkg::byte_t'($urandom));
			end
		end

		case (flaw)
			FLAW_SYNC: f[1] = f[1] ^ sfc_pkg::byte_t'($urandom_range(255, 1));
			FLAW_TYPE: begin
				if (len != 0)
					f[$urandom_range(4, 3)] ^= sfc_pkg::byte_t'($urandom_range(255, 1));
			end
			FLAW_SUM: begin
				if (len >= 3 && has_end)
					f[len + 2] ^= sfc_pkg::byte_t'($urandom_range(255, 1));
			end
			FLAW_END: begin
				if (has_end)
					f[f.size() - 1] ^= sfc_pkg::byte_t'($urandom_range(255, 1));
			end
			default: ;
		endcase

		foreach (f[i])
			pending_bytes.push_back(f[i]);
	endtask

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	// Sender idles little in the first phase, much in the second, never in the third.
	function automatic int unsigned send_idle_pct(input int unsigned ph);
		case (ph)
			0: return 7;
			1: return 74;
			default: return 0;
		endcase
	endfunction

	function automatic int unsigned take_idle_pct(input int unsigned ph);
		case (ph)
			0: return 74;
			1: return 7;
			default: return 0;
		endcase
	endfunction

	// Byte driver: predicts each accepted beat and offers the next pending byte.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_ch.valid <= 1'b0;
			rx_ch.rx_byte <= '0;
		end else begin
			if (rx_ch.valid && rx_ch.ready) begin
				expected_results.push_back(parse_byte(rx_ch.rx_byte));
				void'(pending_bytes.pop_front());
				bytes_sent++;
				if (bytes_sent * 3 / total_items != phase) begin
					phase = bytes_sent * 3 / total_items;
					draining = 1'b1;
				end
			end
			if (!rx_ch.valid || rx_ch.ready) begin
				// Between phases, hold off until every result is back.
				if (draining && expected_results.size() == 0)
					draining = 1'b0;
				drive_next = pending_bytes.size() > 0 && !draining &&
					$urandom_range(99) >= send_idle_pct(phase);
				rx_ch.valid <= drive_next;
				if (drive_next)
					rx_ch.rx_byte <= pending_bytes[0];
			end
		end
	end

	// Result monitor: checks each accepted beat against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result beat arrived with no byte outstanding");
				end else begin
					want = expected_results.pop_front();
					if (res_ch.byte_index !== want.byte_index)
						report_mismatch($sformatf("byte_index %0d, expected %0d",
							res_ch.byte_index, want.byte_index));
					if (res_ch.next_index !== want.next_index)
						report_mismatch($sformatf("next_index %0d, expected %0d (byte_index %0d)",
							res_ch.next_index, want.next_index, want.byte_index));
					if (res_ch.frame_ok !== want.frame_ok)
						report_mismatch($sformatf("frame_ok %b, expected %b (byte_index %0d)",
							res_ch.frame_ok, want.frame_ok, want.byte_index));
					if (res_ch.frame_dropped !== want.frame_dropped)
						report_mismatch($sformatf("frame_dropped %b, expected %b (byte_index %0d)",
							res_ch.frame_dropped, want.frame_dropped, want.byte_index));
					if (want.frame_ok)
						frames_ok++;
					if (want.frame_dropped)
						frames_dropped++;
					if (want.byte_index == BUF_LEN - 1)
						wraps_seen++;
				end
			end
			res_ch.ready <= $urandom_range(99) >= take_idle_pct(phase);
		end
	end

	// Watchdog on cycles in which neither channel moves a beat.
	always @(posedge clk) begin
		if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout: no beat moved in %0d cycles", QUIET_LIMIT);
				$display("[serial_frame_checker] ERROR");
				$finish;
			end
		end
	end

	initial begin
		int unsigned len;
		int unsigned pick;
		int unsigned flaw;

		// Directed: idle noise at the extremes, a good empty frame, a bad second
		// sync byte, a good short frame, a bad type byte, and an empty frame
		// with a bad end marker.
		pending_bytes = {8'h00, 8'hFF};
		queue_frame(0, FLAW_NONE);
		pending_bytes.push_back(sfc_pkg::SYNC0);
		pending_bytes.push_back(8'h55);
		queue_frame(3, FLAW_NONE);
		pending_bytes = {pending_bytes, sfc_pkg::SYNC0, sfc_pkg::SYNC1, 8'h04,
			sfc_pkg::TYPE0, 8'h03};
		pending_bytes = {pending_bytes, sfc_pkg::SYNC0, sfc_pkg::SYNC1, 8'h00,
			sfc_pkg::TYPE0};

		// A frame of length one and one with an unreachable end both run to the wrap.
		queue_frame(1, FLAW_NONE);
		queue_frame(200, FLAW_NONE);

		// Random part: mostly well-formed frames, some spoiled ones, some noise.
		while (pending_bytes.size() < RANDOM_BYTES + 24) begin
			pick = $urandom_range(99);
			if (pick < 15) begin
				repeat ($urandom_range(4, 1))
					pending_bytes.push_back(sfc_pkg::byte_t'($urandom));
			end else begin
				pick = $urandom_range(99);
				if (pick < 10)
					len = 0;
				else if (pick < 14)
					len = $urandom_range(2, 1);
				else if (pick < 17)
					len = $urandom_range(255, BUF_LEN - 3);
				else if (pick < 25)
					len = $urandom_range(BUF_LEN - 4, 13);
				else
					len = $urandom_range(12, 3);
				pick = $urandom_range(99);
				flaw = pick < 60 ? FLAW_NONE : $urandom_range(FLAW_END, FLAW_SYNC);
				queue_frame(len, flaw);
			end
		end
		total_items = pending_bytes.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d bytes under three pacing phases with one drain pause each.",
			bytes_sent);
		$display("Frames accepted: %0d, frames dropped: %0d, buffer wraps: %0d.",
			frames_ok, frames_dropped, wraps_seen);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("[serial_frame_checker] OK");
		else
			$display("[serial_frame_checker] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
